FILE: hdl/hsc_pkg.sv
// shared types, constants and the tan lookup table of the heading steering controller
package hsc_pkg;

    localparam int FRACTION_BITS  = 16;
    localparam int TAN_TABLE_SIZE = 256;
    localparam int TAN_RANGE      = (7 * (1 << FRACTION_BITS)) / 5;
    localparam int MIN_SCALE      = (1 << FRACTION_BITS) / 1000;
    localparam int TAN_W          = 20;
    localparam int TAN_IDX_W      = $clog2(TAN_TABLE_SIZE + 1);

    localparam int SPEED_W = 21;
    localparam int GAIN_W  = 20;
    localparam int AXLE_W  = 18;
    localparam int ANGLE_W = 17;
    localparam int TURN_W  = 22;
    localparam int DT_W    = 17;
    localparam int STEER_W = 18;
    localparam int CFG_W   = 21;
    localparam int CFG_IDX_W = 3;

    // serial unit widths
    localparam int ALU_A_W   = 42;
    localparam int ALU_B_W   = 25;
    localparam int ALU_R_W   = 2 * ALU_B_W;
    localparam int ALU_CNT_W = 6;
    localparam int MUL_STEPS = ALU_B_W;
    localparam int DIV_STEPS = ALU_A_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXLE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND         = 3'd5;

    localparam logic CMD_INCREMENT = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    localparam logic signed [SPEED_W-1:0] RST_SPEED = 21'sd98304;
    localparam logic [GAIN_W-1:0]         RST_GAIN  = 20'd131072;
    localparam logic [AXLE_W-1:0]         RST_AXLE  = 18'd23921;
    localparam logic [ANGLE_W-1:0]        RST_LIMIT = 17'd28596;
    localparam logic [ANGLE_W-1:0]        RST_FLOOR = 17'd1144;
    localparam logic [ANGLE_W-1:0]        RST_BAND  = 17'd572;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef logic [TAN_W-1:0] t_tan_tab [0:TAN_TABLE_SIZE];

    // shift-subtract quotient, used only while the table is built
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tan nodes from sine and cosine series in q30, evaluated at elaboration
    function automatic t_tan_tab build_tan_tab();
        t_tan_tab          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   ts;
        longint unsigned   tc;
        longint unsigned   q30;
        longint            s;
        longint            c;
        for (int i = 0; i <= TAN_TABLE_SIZE; i++) begin
            q30 = longint'(1) << 30;
            x   = udiv64((longint'(i) * longint'(TAN_RANGE)) << (30 - FRACTION_BITS),
                         longint'(TAN_TABLE_SIZE));
            x2  = (x * x) >> 30;
            s   = longint'(x);
            c   = longint'(q30);
            ts  = x;
            tc  = q30;
            for (int k = 1; k <= 12; k++) begin
                ts = udiv64((ts * x2) >> 30, longint'((2 * k) * (2 * k + 1)));
                tc = udiv64((tc * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
                if ((k & 1) == 1) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            if (c <= 0) begin
                c = 1;
            end
            tab[i] = TAN_W'(udiv64(s << FRACTION_BITS, c));
        end
        return tab;
    endfunction

    localparam t_tan_tab TAN_TAB = build_tan_tab();

endpackage

FILE: hdl/hsc_req_if.sv
// request channel of the heading steering controller
interface hsc_req_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cmd;
    logic signed [hsc_pkg::TURN_W-1:0]     turn_increment;
    logic [hsc_pkg::DT_W-1:0]              elapsed_time;

    modport source (output valid, cmd, turn_increment, elapsed_time, input ready);
    modport sink (input valid, cmd, turn_increment, elapsed_time, output ready);
endinterface

FILE: hdl/hsc_rsp_if.sv
// result channel of the heading steering controller
interface hsc_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [hsc_pkg::SPEED_W-1:0]    speed_command;
    logic signed [hsc_pkg::STEER_W-1:0]    steering_command;
    logic                                  turning;

    modport source (output valid, speed_command, steering_command, turning, input ready);
    modport sink (input valid, speed_command, steering_command, turning, output ready);
endinterface

FILE: hdl/hsc_serial_alu.sv
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
module hsc_serial_alu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hsc_pkg::t_alu_req               i_req,
    input  logic [hsc_pkg::ALU_A_W-1:0]     i_opa,
    input  logic [hsc_pkg::ALU_B_W-1:0]     i_opb,
    output logic [hsc_pkg::ALU_R_W-1:0]     o_res,
    output logic [hsc_pkg::AXLE_W-1:0]      o_rem,
    output logic                            o_done
);

    localparam int BW = hsc_pkg::ALU_B_W;
    localparam int AW = hsc_pkg::ALU_A_W;
    localparam int RW = hsc_pkg::ALU_R_W;
    localparam int DW = hsc_pkg::AXLE_W;

    logic                            r_busy;
    logic                            r_done;
    hsc_pkg::t_alu_op                r_op;
    logic [hsc_pkg::ALU_CNT_W-1:0]   r_cnt;
    logic [RW-1:0]                   r_acc;
    logic [BW-1:0]                   r_mplr;
    logic [BW-1:0]                   r_b;
    logic [DW-1:0]                   r_rem;

    logic [BW:0]   mul_sum;
    logic [DW:0]   div_shift;
    logic [DW+1:0] div_diff;
    logic          div_ge;

    always_comb begin
        mul_sum   = {1'b0, r_acc[RW-1:BW]} + (r_mplr[0] ? {1'b0, r_b} : '0);
        div_shift = {r_rem, r_acc[AW-1]};
        div_diff  = {1'b0, div_shift} - {2'b00, r_b[DW-1:0]};
        div_ge    = !div_diff[DW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= hsc_pkg::ALU_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                case (i_req.op)
                    hsc_pkg::ALU_MUL: begin
                        r_cnt  <= hsc_pkg::ALU_CNT_W'(hsc_pkg::MUL_STEPS - 1);
                        r_acc  <= '0;
                        r_b    <= i_opa[BW-1:0];
                        r_mplr <= i_opb;
                    end
                    hsc_pkg::ALU_DIV: begin
                        r_cnt  <= hsc_pkg::ALU_CNT_W'(hsc_pkg::DIV_STEPS - 1);
                        r_acc  <= RW'(i_opa);
                        r_b    <= i_opb;
                        r_rem  <= '0;
                    end
                    default: begin
                        r_cnt <= '0;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    hsc_pkg::ALU_MUL: begin
                        r_acc  <= {mul_sum, r_acc[BW-1:1]};
                        r_mplr <= r_mplr >> 1;
                    end
                    hsc_pkg::ALU_DIV: begin
                        r_rem         <= div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
                        r_acc[AW-1:0] <= {r_acc[AW-2:0], div_ge};
                    end
                    default: begin
                        r_rem <= r_rem;
                    end
                endcase
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_res  = r_acc;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

FILE: hdl/heading_steering_controller.sv
// heading steering controller top level: state, sequencer and result register
//
// requests come in on i_req: cmd low adds turn_increment to the remaining heading
// change (saturating) and gives no result; cmd high is a control tick with
// elapsed_time, and a tick with nonzero elapsed time gives one result on o_rsp.
// configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while the block is idle, which the block does not
// enforce itself; indexes above five are ignored. an increment request or a zero-time
// tick is done in the idle state; a tick inside the band goes to the result stage and
// the update. outside it steering is formed by the gain multiply and the floor clamp
// and placed in the result register; with the turn estimate off the tick then ends in
// the update. otherwise the estimate runs a chain of three multiplies and three divides
// through one bit-serial unit, without interpolation when steering hits the table end.
// one request is in work at a time; i_req.ready is high only between requests.
// the result register frees the sequencer: a result waiting on a stalled
// receiver holds its values, and the tick only pauses at the point where it
// must load the next result while the previous one is still waiting.
// reset clears the remaining change and turning mode and restores the
// register defaults; it takes effect at once, with no clearing pass.
module heading_steering_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hsc_pkg::CFG_W-1:0]         i_cfg_data,
    hsc_req_if.sink                           i_req,
    hsc_rsp_if.source                         o_rsp
);

    localparam int FB = hsc_pkg::FRACTION_BITS;
    localparam int AW = hsc_pkg::ALU_A_W;
    localparam int BW = hsc_pkg::ALU_B_W;
    localparam int TW = hsc_pkg::TURN_W;
    localparam int RW = hsc_pkg::ALU_R_W;
    localparam int MW = AW - FB;
    localparam logic [hsc_pkg::ANGLE_W-1:0] TAN_RANGE_V = hsc_pkg::ANGLE_W'(hsc_pkg::TAN_RANGE);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG_MUL,
        ST_CLAMP,
        ST_EMIT,
        ST_IDX_DIV,
        ST_INTERP_MUL,
        ST_INTERP_DIV,
        ST_SPEED_MUL,
        ST_DT_MUL,
        ST_YAW_DIV,
        ST_UPDATE
    } t_state;

    t_state                                   r_state;

    logic signed [hsc_pkg::SPEED_W-1:0]       r_speed;
    logic [hsc_pkg::GAIN_W-1:0]               r_gain;
    logic [hsc_pkg::AXLE_W-1:0]               r_axle;
    logic [hsc_pkg::ANGLE_W-1:0]              r_limit;
    logic [hsc_pkg::ANGLE_W-1:0]              r_floor;
    logic [hsc_pkg::ANGLE_W-1:0]              r_band;

    logic signed [TW-1:0]                     r_rt;
    logic                                     r_mode;
    logic [hsc_pkg::DT_W-1:0]                 r_dt;
    logic [hsc_pkg::ANGLE_W-1:0]              r_mag;
    logic [hsc_pkg::TAN_W-1:0]                r_lo;
    logic [AW-1:0]                            r_e;

    logic                                     r_out_valid;
    logic signed [hsc_pkg::SPEED_W-1:0]       r_out_speed;
    logic signed [hsc_pkg::STEER_W-1:0]       r_out_steer;
    logic                                     r_out_turning;

    hsc_pkg::t_alu_req                        r_alu_req;
    logic [AW-1:0]                            r_alu_opa;
    logic [BW-1:0]                            r_alu_opb;
    logic [RW-1:0]                            alu_res;
    logic [hsc_pkg::AXLE_W-1:0]               alu_rem;
    logic                                     alu_done;

    logic [TW-1:0]                            rmag;
    logic signed [TW:0]                       inc_sum;
    logic signed [TW-1:0]                     inc_sat;
    logic [TW-1:0]                            inc_mag;
    logic [hsc_pkg::ANGLE_W-1:0]              lim;
    logic [AW-1:0]                            rounded;
    logic [MW-1:0]                            mag_raw;
    logic [hsc_pkg::ANGLE_W-1:0]              mag_lim;
    logic [hsc_pkg::ANGLE_W-1:0]              floor_lim;
    logic [hsc_pkg::SPEED_W-1:0]              speed_mag;
    logic                                     yaw_on;
    logic [hsc_pkg::TAN_IDX_W-1:0]            tan_idx;
    logic [hsc_pkg::TAN_W-1:0]                tan_lo;
    logic [hsc_pkg::TAN_W-1:0]                tan_hi;
    logic [hsc_pkg::TAN_W-1:0]                tan_diff;
    logic [hsc_pkg::TAN_W-1:0]                tan_val;
    logic                                     exec_neg;
    logic                                     same_dir;
    logic [TW-1:0]                            left_mag;
    logic                                     out_free;

    hsc_serial_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_alu_req),
        .i_opa   (r_alu_opa),
        .i_opb   (r_alu_opb),
        .o_res   (alu_res),
        .o_rem   (alu_rem),
        .o_done  (alu_done)
    );

    always_comb begin
        rmag      = r_rt[TW-1] ? TW'(-r_rt) : TW'(r_rt);
        inc_sum   = {r_rt[TW-1], r_rt} + {i_req.turn_increment[TW-1], i_req.turn_increment};
        if (inc_sum[TW] != inc_sum[TW-1]) begin
            inc_sat = inc_sum[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end else begin
            inc_sat = inc_sum[TW-1:0];
        end
        inc_mag   = inc_sat[TW-1] ? TW'(-inc_sat) : TW'(inc_sat);
        lim       = (r_limit < TAN_RANGE_V) ? r_limit : TAN_RANGE_V;
        // round the gain product half away from zero
        rounded   = alu_res[AW-1:0] + AW'(1 << (FB - 1));
        mag_raw   = rounded[AW-1:FB];
        mag_lim   = (mag_raw > MW'(lim)) ? lim : mag_raw[hsc_pkg::ANGLE_W-1:0];
        floor_lim = (r_floor > lim) ? lim : r_floor;
        speed_mag = r_speed[hsc_pkg::SPEED_W-1] ? hsc_pkg::SPEED_W'(-r_speed)
                                                : hsc_pkg::SPEED_W'(r_speed);
        yaw_on    = (r_axle > hsc_pkg::AXLE_W'(hsc_pkg::MIN_SCALE))
                 && (speed_mag > hsc_pkg::SPEED_W'(hsc_pkg::MIN_SCALE))
                 && (r_mag != '0);
        tan_idx   = alu_res[hsc_pkg::TAN_IDX_W-1:0];
        tan_lo    = hsc_pkg::TAN_TAB[tan_idx];
        tan_hi    = (tan_idx < hsc_pkg::TAN_IDX_W'(hsc_pkg::TAN_TABLE_SIZE))
                  ? hsc_pkg::TAN_TAB[tan_idx + 1'b1] : tan_lo;
        tan_diff  = (tan_hi < tan_lo) ? '0 : tan_hi - tan_lo;
        tan_val   = r_lo + alu_res[hsc_pkg::TAN_W-1:0];
        exec_neg  = r_speed[hsc_pkg::SPEED_W-1] != r_rt[TW-1];
        same_dir  = (r_e != '0)
                 && ((!r_rt[TW-1] && (r_rt != '0) && !exec_neg) || (r_rt[TW-1] && exec_neg));
        left_mag  = rmag - r_e[TW-1:0];
        out_free  = !r_out_valid || o_rsp.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_speed       <= hsc_pkg::RST_SPEED;
            r_gain        <= hsc_pkg::RST_GAIN;
            r_axle        <= hsc_pkg::RST_AXLE;
            r_limit       <= hsc_pkg::RST_LIMIT;
            r_floor       <= hsc_pkg::RST_FLOOR;
            r_band        <= hsc_pkg::RST_BAND;
            r_rt          <= '0;
            r_mode        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_alu_req     <= '{start: 1'b0, op: hsc_pkg::ALU_MUL};
        end else begin
            // start is a one-cycle pulse; no state raises it while it is high
            if (r_alu_req.start) begin
                r_alu_req.start <= 1'b0;
            end
            if (r_out_valid && o_rsp.ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    hsc_pkg::CFG_CRUISE_SPEED: r_speed <= i_cfg_data;
                    hsc_pkg::CFG_GAIN:         r_gain  <= i_cfg_data[hsc_pkg::GAIN_W-1:0];
                    hsc_pkg::CFG_AXLE:         r_axle  <= i_cfg_data[hsc_pkg::AXLE_W-1:0];
                    hsc_pkg::CFG_LIMIT:        r_limit <= i_cfg_data[hsc_pkg::ANGLE_W-1:0];
                    hsc_pkg::CFG_FLOOR:        r_floor <= i_cfg_data[hsc_pkg::ANGLE_W-1:0];
                    hsc_pkg::CFG_BAND:         r_band  <= i_cfg_data[hsc_pkg::ANGLE_W-1:0];
                    default: begin
                        r_band <= r_band;
                    end
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.cmd == hsc_pkg::CMD_INCREMENT) begin
                            r_rt <= inc_sat;
                            if (inc_mag > TW'(r_band)) begin
                                r_mode <= 1'b1;
                            end
                        end else if (i_req.elapsed_time != '0) begin
                            r_dt <= i_req.elapsed_time;
                            if (rmag > TW'(r_band)) begin
                                r_mode          <= 1'b1;
                                r_alu_req       <= '{start: 1'b1, op: hsc_pkg::ALU_MUL};
                                r_alu_opa       <= AW'(r_gain);
                                r_alu_opb       <= BW'(rmag);
                                r_state         <= ST_MAG_MUL;
                            end else begin
                                r_rt    <= '0;
                                r_mode  <= 1'b0;
                                r_mag   <= '0;
                                r_state <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_MAG_MUL: begin
                    if (alu_done) begin
                        r_mag   <= mag_lim;
                        r_state <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    // lift a small nonzero steering to the floor
                    if ((r_mag != '0) && (r_mag < r_floor)) begin
                        r_mag <= floor_lim;
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_speed   <= r_speed;
                        r_out_steer   <= r_rt[TW-1]
                                       ? -hsc_pkg::STEER_W'(r_mag)
                                       : hsc_pkg::STEER_W'(r_mag);
                        r_out_turning <= r_mode;
                        if (yaw_on) begin
                            r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_DIV};
                            r_alu_opa <= AW'(r_mag) << $clog2(hsc_pkg::TAN_TABLE_SIZE);
                            r_alu_opb <= BW'(hsc_pkg::TAN_RANGE);
                            r_state   <= ST_IDX_DIV;
                        end else begin
                            r_e     <= '0;
                            r_state <= ST_UPDATE;
                        end
                    end
                end
                ST_IDX_DIV: begin
                    if (alu_done) begin
                        if (tan_idx >= hsc_pkg::TAN_IDX_W'(hsc_pkg::TAN_TABLE_SIZE)) begin
                            r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_MUL};
                            r_alu_opa <= AW'(speed_mag);
                            r_alu_opb <= BW'(tan_lo);
                            r_state   <= ST_SPEED_MUL;
                        end else begin
                            r_lo      <= tan_lo;
                            r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_MUL};
                            r_alu_opa <= AW'(tan_diff);
                            r_alu_opb <= BW'(alu_rem);
                            r_state   <= ST_INTERP_MUL;
                        end
                    end
                end
                ST_INTERP_MUL: begin
                    if (alu_done) begin
                        r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_DIV};
                        r_alu_opa <= alu_res[AW-1:0];
                        r_alu_opb <= BW'(hsc_pkg::TAN_RANGE);
                        r_state   <= ST_INTERP_DIV;
                    end
                end
                ST_INTERP_DIV: begin
                    if (alu_done) begin
                        r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_MUL};
                        r_alu_opa <= AW'(speed_mag);
                        r_alu_opb <= BW'(tan_val);
                        r_state   <= ST_SPEED_MUL;
                    end
                end
                ST_SPEED_MUL: begin
                    if (alu_done) begin
                        r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_MUL};
                        r_alu_opa <= AW'(alu_res[FB+BW-1:FB]);
                        r_alu_opb <= BW'(r_dt);
                        r_state   <= ST_DT_MUL;
                    end
                end
                ST_DT_MUL: begin
                    if (alu_done) begin
                        r_alu_req <= '{start: 1'b1, op: hsc_pkg::ALU_DIV};
                        r_alu_opa <= alu_res[AW-1:0];
                        r_alu_opb <= BW'(r_axle);
                        r_state   <= ST_YAW_DIV;
                    end
                end
                ST_YAW_DIV: begin
                    if (alu_done) begin
                        r_e     <= alu_res[AW-1:0];
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    // never step past zero
                    if (same_dir) begin
                        if (r_e >= AW'(rmag)) begin
                            r_rt <= '0;
                        end else begin
                            r_rt <= r_rt[TW-1] ? -$signed(left_mag) : $signed(left_mag);
                        end
                    end else if (rmag <= TW'(r_band)) begin
                        r_rt <= '0;
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready            = (r_state == ST_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.speed_command    = r_out_speed;
    assign o_rsp.steering_command = r_out_steer;
    assign o_rsp.turning          = r_out_turning;

    a_steer_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_steer <= $signed(hsc_pkg::STEER_W'(hsc_pkg::TAN_RANGE)))
                     && (r_out_steer >= -$signed(hsc_pkg::STEER_W'(hsc_pkg::TAN_RANGE))))
        else $error("steering beyond table range");

    a_straight_no_steer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_turning) |-> (r_out_steer == '0))
        else $error("steering while in straight mode");

    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=> (rmag <= $past(rmag)))
        else $error("remaining heading change grew on a tick");

    a_alu_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alu_req.start |-> ((r_state == ST_MAG_MUL) || (r_state == ST_IDX_DIV)
                          || (r_state == ST_INTERP_MUL) || (r_state == ST_INTERP_DIV)
                          || (r_state == ST_SPEED_MUL) || (r_state == ST_DT_MUL)
                          || (r_state == ST_YAW_DIV)))
        else $error("serial unit started outside an arithmetic state");

endmodule

FILE: tb/sv/tb_heading_steering_controller.sv
// testbench of the heading steering controller: scoreboard, request and result drivers
`timescale 1ns / 100ps

typedef struct {
    logic signed [hsc_pkg::SPEED_W-1:0] speed;
    logic signed [hsc_pkg::STEER_W-1:0] steer;
    logic                               turning;
} t_steer_result;

class steering_scoreboard;
    localparam longint TURN_HI = (longint'(1) << 21) - 1;
    localparam longint TURN_LO = -(longint'(1) << 21);

    longint unsigned tan_node [0:hsc_pkg::TAN_TABLE_SIZE];
    longint          cruise;
    longint unsigned gain;
    longint unsigned axle;
    longint unsigned limit;
    longint unsigned floor_ang;
    longint unsigned band;
    longint          remaining;
    bit              turning_mode;
    t_steer_result   pending_results [$];
    int              errors;

    function new();
        longint unsigned x, x2, ts, tc;
        longint          s, c;
        for (int i = 0; i <= hsc_pkg::TAN_TABLE_SIZE; i++) begin
            x  = ((longint'(i) * hsc_pkg::TAN_RANGE) << (30 - hsc_pkg::FRACTION_BITS))
                 / hsc_pkg::TAN_TABLE_SIZE;
            x2 = (x * x) >> 30;
            s  = longint'(x);
            c  = longint'(1) << 30;
            ts = x;
            tc = longint'(1) << 30;
            for (int k = 1; k <= 12; k++) begin
                ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    s = s - longint'(ts);
                    c = c - longint'(tc);
                end else begin
                    s = s + longint'(ts);
                    c = c + longint'(tc);
                end
            end
            if (s < 0) s = 0;
            if (c <= 0) c = 1;
            tan_node[i] = (longint'(s) << hsc_pkg::FRACTION_BITS) / c;
        end
        cruise       = hsc_pkg::RST_SPEED;
        gain         = hsc_pkg::RST_GAIN;
        axle         = hsc_pkg::RST_AXLE;
        limit        = hsc_pkg::RST_LIMIT;
        floor_ang    = hsc_pkg::RST_FLOOR;
        band         = hsc_pkg::RST_BAND;
        remaining    = 0;
        turning_mode = 0;
        errors       = 0;
    endfunction

    function longint unsigned magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    function longint unsigned tan_lookup(longint unsigned m);
        longint unsigned pos, idx, frac, lo, hi;
        if (m > hsc_pkg::TAN_RANGE) m = hsc_pkg::TAN_RANGE;
        pos  = m * hsc_pkg::TAN_TABLE_SIZE;
        idx  = pos / hsc_pkg::TAN_RANGE;
        frac = pos % hsc_pkg::TAN_RANGE;
        if (idx >= hsc_pkg::TAN_TABLE_SIZE) return tan_node[hsc_pkg::TAN_TABLE_SIZE];
        lo = tan_node[idx];
        hi = tan_node[idx + 1];
        if (hi < lo) hi = lo;
        return lo + ((hi - lo) * frac) / hsc_pkg::TAN_RANGE;
    endfunction

    function void set_reg(logic [hsc_pkg::CFG_IDX_W-1:0] idx, logic [hsc_pkg::CFG_W-1:0] data);
        case (idx)
            hsc_pkg::CFG_CRUISE_SPEED:
                cruise = longint'($signed(data[hsc_pkg::SPEED_W-1:0]));
            hsc_pkg::CFG_GAIN:  gain = data[hsc_pkg::GAIN_W-1:0];
            hsc_pkg::CFG_AXLE:  axle = data[hsc_pkg::AXLE_W-1:0];
            hsc_pkg::CFG_LIMIT: limit = data[hsc_pkg::ANGLE_W-1:0];
            hsc_pkg::CFG_FLOOR: floor_ang = data[hsc_pkg::ANGLE_W-1:0];
            hsc_pkg::CFG_BAND:  band = data[hsc_pkg::ANGLE_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_request(logic cmd, logic signed [hsc_pkg::TURN_W-1:0] inc,
                               logic [hsc_pkg::DT_W-1:0] dt);
        longint          sum, steer, exec_turn;
        longint unsigned lim, mag, rmag, a, e;
        t_steer_result   res;
        if (cmd == hsc_pkg::CMD_INCREMENT) begin
            sum = remaining + longint'(inc);
            if (sum > TURN_HI) sum = TURN_HI;
            if (sum < TURN_LO) sum = TURN_LO;
            remaining = sum;
            if (magnitude(sum) > band) turning_mode = 1;
            return;
        end
        if (dt == 0) return;
        lim   = limit < hsc_pkg::TAN_RANGE ? limit : hsc_pkg::TAN_RANGE;
        rmag  = magnitude(remaining);
        mag   = 0;
        steer = 0;
        exec_turn = 0;
        if (rmag > band) begin
            turning_mode = 1;
            mag = (gain * rmag + (longint'(1) << (hsc_pkg::FRACTION_BITS - 1)))
                  >> hsc_pkg::FRACTION_BITS;
            if (mag > lim) mag = lim;
            if (mag > 0 && mag < floor_ang) begin
                mag = floor_ang;
                if (mag > lim) mag = lim;
            end
            steer = remaining < 0 ? -longint'(mag) : longint'(mag);
        end else begin
            remaining    = 0;
            turning_mode = 0;
        end
        res.speed   = cruise[hsc_pkg::SPEED_W-1:0];
        res.steer   = steer[hsc_pkg::STEER_W-1:0];
        res.turning = turning_mode;
        pending_results.push_back(res);
        // yaw estimate only when wheelbase and speed are above one thousandth
        if (axle * 1000 > (longint'(1) << hsc_pkg::FRACTION_BITS)
            && magnitude(cruise) * 1000 > (longint'(1) << hsc_pkg::FRACTION_BITS)
            && mag > 0) begin
            a = (magnitude(cruise) * tan_lookup(mag)) >> hsc_pkg::FRACTION_BITS;
            e = (a * dt) / axle;
            exec_turn = ((cruise < 0) != (steer < 0)) ? -longint'(e) : longint'(e);
        end
        if ((remaining > 0 && exec_turn > 0) || (remaining < 0 && exec_turn < 0)) begin
            if (magnitude(exec_turn) >= magnitude(remaining)) remaining = 0;
            else remaining = remaining - exec_turn;
        end else if (magnitude(remaining) <= band) begin
            remaining = 0;
        end
    endfunction

    function void check_result(t_steer_result got);
        t_steer_result want;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result speed %0d steer %0d turning %0d",
                     $time, got.speed, got.steer, got.turning);
            return;
        end
        want = pending_results.pop_front();
        if (got.speed !== want.speed) begin
            errors++;
            $display("%0t: speed_command expected %0d actual %0d", $time, want.speed, got.speed);
        end
        if (got.steer !== want.steer) begin
            errors++;
            $display("%0t: steering_command expected %0d actual %0d",
                     $time, want.steer, got.steer);
        end
        if (got.turning !== want.turning) begin
            errors++;
            $display("%0t: turning expected %0d actual %0d", $time, want.turning, got.turning);
        end
    endfunction
endclass

module tb_heading_steering_controller;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 400;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [hsc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [hsc_pkg::CFG_W-1:0]     i_cfg_data;

    hsc_req_if req_ch ();
    hsc_rsp_if rsp_ch ();

    heading_steering_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    steering_scoreboard steer_sb = new();
    bit no_idle;
    int stall_left;
    int idle_count;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_steer_result got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.speed   = rsp_ch.speed_command;
            got.steer   = rsp_ch.steering_command;
            got.turning = rsp_ch.turning;
            steer_sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("heading_steering_controller test failed");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic cmd, logic signed [hsc_pkg::TURN_W-1:0] inc,
                                logic [hsc_pkg::DT_W-1:0] dt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          = 1'b1;
        req_ch.cmd            = cmd;
        req_ch.turn_increment = inc;
        req_ch.elapsed_time   = dt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        steer_sb.note_request(cmd, inc, dt);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [hsc_pkg::CFG_IDX_W-1:0] idx,
                             logic [hsc_pkg::CFG_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        steer_sb.set_reg(idx, data);
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (steer_sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_request();
        logic signed [hsc_pkg::TURN_W-1:0] inc;
        logic [hsc_pkg::DT_W-1:0]          dt;
        int                                r;
        r = $urandom_range(0, 99);
        if (r < 15) inc = hsc_pkg::TURN_W'($urandom_range(0, (1 << hsc_pkg::TURN_W) - 1));
        else inc = hsc_pkg::TURN_W'($signed($urandom_range(0, 400000)) - 200000);
        r = $urandom_range(0, 99);
        if (r < 6) dt = '0;
        else if (r < 16) dt = hsc_pkg::DT_W'($urandom_range(0, (1 << hsc_pkg::DT_W) - 1));
        else dt = hsc_pkg::DT_W'($urandom_range(500, 20000));
        send_request($urandom_range(0, 99) < 55 ? hsc_pkg::CMD_TICK : hsc_pkg::CMD_INCREMENT,
                     inc, dt);
    endtask

    task automatic load_config(int phase);
        logic signed [hsc_pkg::CFG_W-1:0] speed;
        case (phase)
            1: begin
                write_reg(hsc_pkg::CFG_CRUISE_SPEED, 21'h100000);
                write_reg(hsc_pkg::CFG_GAIN, 21'd1048575);
                write_reg(hsc_pkg::CFG_AXLE, 21'd262143);
                write_reg(hsc_pkg::CFG_LIMIT, 21'd91750);
                write_reg(hsc_pkg::CFG_FLOOR, 21'd91750);
                write_reg(hsc_pkg::CFG_BAND, 21'd65536);
            end
            2: begin
                write_reg(hsc_pkg::CFG_CRUISE_SPEED, 21'h0FFFFF);
                write_reg(hsc_pkg::CFG_GAIN, '0);
                write_reg(hsc_pkg::CFG_AXLE, '0);
                write_reg(hsc_pkg::CFG_LIMIT, '0);
                write_reg(hsc_pkg::CFG_FLOOR, '0);
                write_reg(hsc_pkg::CFG_BAND, '0);
            end
            3: begin
                // right at the one-thousandth thresholds
                write_reg(hsc_pkg::CFG_CRUISE_SPEED,
                          $urandom_range(0, 1) ? 21'd66 : -21'sd65);
                write_reg(hsc_pkg::CFG_GAIN, 21'd65536);
                write_reg(hsc_pkg::CFG_AXLE, $urandom_range(0, 1) ? 21'd65 : 21'd66);
                write_reg(hsc_pkg::CFG_LIMIT, 21'd91750);
                write_reg(hsc_pkg::CFG_FLOOR, 21'd5000);
                write_reg(hsc_pkg::CFG_BAND, 21'd100);
            end
            default: begin
                speed = hsc_pkg::CFG_W'($signed($urandom_range(0, 400000)) - 200000);
                if ($urandom_range(0, 3) == 0) begin
                    speed = hsc_pkg::CFG_W'($urandom_range(0, (1 << hsc_pkg::SPEED_W) - 1));
                end
                write_reg(hsc_pkg::CFG_CRUISE_SPEED, speed);
                write_reg(hsc_pkg::CFG_GAIN, $urandom_range(0, 3) == 0
                          ? hsc_pkg::CFG_W'($urandom_range(0, 1048575))
                          : hsc_pkg::CFG_W'($urandom_range(0, 300000)));
                write_reg(hsc_pkg::CFG_AXLE, hsc_pkg::CFG_W'($urandom_range(5000, 262143)));
                write_reg(hsc_pkg::CFG_LIMIT, hsc_pkg::CFG_W'($urandom_range(0, 91750)));
                write_reg(hsc_pkg::CFG_FLOOR, hsc_pkg::CFG_W'($urandom_range(0, 30000)));
                write_reg(hsc_pkg::CFG_BAND, hsc_pkg::CFG_W'($urandom_range(0, 8000)));
            end
        endcase
        // unused indexes must leave every register alone
        write_reg(3'd6, hsc_pkg::CFG_W'($urandom_range(0, (1 << hsc_pkg::CFG_W) - 1)));
        write_reg(3'd7, hsc_pkg::CFG_W'($urandom_range(0, (1 << hsc_pkg::CFG_W) - 1)));
    endtask

    initial begin
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = hsc_pkg::CMD_INCREMENT;
        req_ch.turn_increment = '0;
        req_ch.elapsed_time   = '0;
        no_idle               = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed requests on reset defaults
        send_request(hsc_pkg::CMD_TICK, '0, 17'd1000);
        send_request(hsc_pkg::CMD_INCREMENT, 22'sd2097151, '0);
        send_request(hsc_pkg::CMD_INCREMENT, 22'sd2097151, '0);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd131071);
        send_request(hsc_pkg::CMD_TICK, 22'sd5, '0);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd1);
        send_request(hsc_pkg::CMD_INCREMENT, -22'sd2097152, '0);
        send_request(hsc_pkg::CMD_INCREMENT, -22'sd2097152, '0);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd131071);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd65536);
        send_request(hsc_pkg::CMD_INCREMENT, 22'sd2097151, '0);
        send_request(hsc_pkg::CMD_INCREMENT, 22'sd300, '0);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd6554);
        send_request(hsc_pkg::CMD_INCREMENT, -22'sd700, '0);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd6554);
        send_request(hsc_pkg::CMD_INCREMENT, 22'sd20000, '0);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd6554);
        send_request(hsc_pkg::CMD_TICK, '0, 17'd6554);

        for (int phase = 1; phase <= 11; phase++) begin
            wait_idle();
            load_config(phase);
            no_idle = (phase % 4 == 0);
            for (int n = 0; n < 50; n++) random_request();
        end

        wait_idle();
        if (steer_sb.errors == 0) begin
            $display("heading_steering_controller test passed");
        end else begin
            $display("heading_steering_controller test failed");
        end
        $finish;
    end
endmodule
